FILE: rtl/egcd_pkg.sv
// shared types and constants for the extended gcd unit
package egcd_pkg;

   // fixed field widths of the transfer channels
   localparam int unsigned OPND_W     = 32;
   localparam int unsigned COEF_W     = 33;
   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 104;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_DIVIDE,
      ST_UPDATE,
      ST_FINISH
   } egcd_state_type;

endpackage

FILE: rtl/egcd_div_step.sv
// one restoring division step with shift-add accumulation of quotient times coefficients
module egcd_div_step #(
   parameter int unsigned OW = 32,
   parameter int unsigned CW = 33
) (
   input  logic [OW-1:0] rem,
   input  logic [OW-1:0] dsh,
   input  logic [CW-1:0] na,
   input  logic [CW-1:0] nb,
   input  logic [CW-1:0] pa,
   input  logic [CW-1:0] pb,
   output logic [OW-1:0] rem_next,
   output logic [CW-1:0] pa_next,
   output logic [CW-1:0] pb_next
);

   logic q_bit;

   // quotient bit comes out msb first, so the products double before each add
   assign q_bit    = (rem >= dsh);
   assign rem_next = q_bit ? (rem - dsh) : rem;
   assign pa_next  = {pa[CW-2:0], 1'b0} + (q_bit ? na : '0);
   assign pb_next  = {pb[CW-2:0], 1'b0} + (q_bit ? nb : '0);

endmodule

FILE: rtl/extended_gcd_bezout_unit.sv
// top level of the extended euclidean gcd unit with bezout coefficients
//
//   channel | dir | fields (lsb first)                              | transfer when
//   req_    | in  | operand_a[31:0], operand_b[63:32]               | req_tvalid & req_tready
//   rsp_    | out | divisor[31:0], coef_a[64:32], coef_b[97:65]     | rsp_tvalid & rsp_tready
//
// each euclid step aligns the divisor up one bit per cycle, then runs one restoring
// division bit per cycle through the shared step unit, then an update state; the worst case
// is adjacent fibonacci operands with a below b, which give the most euclid steps
// one item in the sequencer at a time; req_tready is high only while the sequencer is idle
// reset is synchronous, active high, and clears the sequencer and the result valid
// a stalled result sits in the output register; the next item may be computed meanwhile
module extended_gcd_bezout_unit #(
   parameter int unsigned WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // operand_a [31:0], operand_b [63:32]
   input  logic [egcd_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // divisor [31:0], coef_a [64:32], coef_b [97:65], zero fill [103:98]
   output logic [egcd_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   import egcd_pkg::*;

   // operand bits above 32 never arrive, so the datapath stops there
   localparam int unsigned OW = (WIDTH < OPND_W) ? WIDTH : OPND_W;
   localparam int unsigned CW = OW + 1;
   localparam int unsigned KW = $clog2(OW);
   localparam int unsigned PAD_W = RSP_DATA_W - OPND_W - 2 * COEF_W;

   egcd_state_type state_ff, state_in;

   // running remainder (numerator at step start), divisor, aligned divisor
   logic [OW-1:0] rem_ff, rem_in;
   logic [OW-1:0] den_ff, den_in;
   logic [OW-1:0] dsh_ff, dsh_in;
   logic [KW-1:0] k_ff, k_in;

   // coefficient pairs and quotient products, wrapping two's complement
   logic [CW-1:0] ca_ff, ca_in, cb_ff, cb_in;
   logic [CW-1:0] na_ff, na_in, nb_ff, nb_in;
   logic [CW-1:0] pa_ff, pa_in, pb_ff, pb_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [OW-1:0] step_rem;
   logic [CW-1:0] step_pa, step_pb;
   logic [OW:0]   dsh_dbl;
   logic [OW-1:0] opnd_a, opnd_b;

   assign opnd_a  = req_tdata[OW-1:0];
   assign opnd_b  = req_tdata[OPND_W+OW-1:OPND_W];
   assign dsh_dbl = {dsh_ff, 1'b0};

   egcd_div_step #(
      .OW(OW),
      .CW(CW)
   ) u_step (
      .rem      (rem_ff),
      .dsh      (dsh_ff),
      .na       (na_ff),
      .nb       (nb_ff),
      .pa       (pa_ff),
      .pb       (pb_ff),
      .rem_next (step_rem),
      .pa_next  (step_pa),
      .pb_next  (step_pb)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      dsh_in       = dsh_ff;
      k_in         = k_ff;
      ca_in        = ca_ff;
      cb_in        = cb_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               rem_in = opnd_a;
               den_in = opnd_b;
               dsh_in = opnd_b;
               k_in   = '0;
               ca_in  = CW'(1);
               cb_in  = '0;
               na_in  = '0;
               nb_in  = CW'(1);
               pa_in  = '0;
               pb_in  = '0;
               // zero second operand: gcd is the first operand, coefficients 1 and 0
               state_in = (opnd_b == '0) ? ST_FINISH : ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            // shift the divisor up while it still fits under the numerator
            if (dsh_dbl <= {1'b0, rem_ff}) begin
               dsh_in = dsh_dbl[OW-1:0];
               k_in   = k_ff + KW'(1);
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in = step_rem;
            pa_in  = step_pa;
            pb_in  = step_pb;
            dsh_in = dsh_ff >> 1;
            if (k_ff == '0) begin
               state_in = ST_UPDATE;
            end else begin
               k_in = k_ff - KW'(1);
            end
         end
         ST_UPDATE: begin
            // (num, den) <- (den, rem); new coefficient = old - quotient * current
            rem_in = den_ff;
            den_in = rem_ff;
            dsh_in = rem_ff;
            k_in   = '0;
            ca_in  = na_ff;
            na_in  = ca_ff - pa_ff;
            cb_in  = nb_ff;
            nb_in  = cb_ff - pb_ff;
            pa_in  = '0;
            pb_in  = '0;
            state_in = (rem_ff == '0) ? ST_FINISH : ST_ALIGN;
         end
         ST_FINISH: begin
            // wait for the output register to empty
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {{PAD_W{1'b0}}, COEF_W'(cb_ff), COEF_W'(ca_ff),
                               OPND_W'(rem_ff)};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      dsh_ff      <= dsh_in;
      k_ff        <= k_in;
      ca_ff       <= ca_in;
      cb_ff       <= cb_in;
      na_ff       <= na_in;
      nb_ff       <= nb_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: verif/tb_top.sv
// self-checking testbench for the extended gcd unit: directed and random operand pairs
`timescale 1ns / 100ps

module tb_top;
   import egcd_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 5000;  // cycles with no transfer on either side
   localparam int unsigned DRAIN_CYCLES   = 600;   // several worst-case items

   // one result, divisor in the low bits as on rsp_tdata
   typedef struct packed {
      logic [COEF_W-1:0] coef_b;
      logic [COEF_W-1:0] coef_a;
      logic [OPND_W-1:0] divisor;
   } bezout_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   bezout_type  pending_bezout[$];
   int unsigned fail_count    = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned ready_hold    = 0;
   int unsigned gap_percent   = 0;   // chance of a sender gap before an item
   int unsigned stall_percent = 0;   // chance of a receiver stall burst per cycle

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   extended_gcd_bezout_unit #(
      .WIDTH(OPND_W)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // euclid on 64-bit wrapping coefficients, then cut to the result widths
   function automatic bezout_type compute_bezout(input logic [OPND_W-1:0] a,
                                                 input logic [OPND_W-1:0] b);
      logic [63:0] num, den, quo, rem, ca, cb, na, nb, nxt;
      bezout_type  res;
      num = 64'(a);
      den = 64'(b);
      ca  = 64'd1;
      cb  = 64'd0;
      na  = 64'd0;
      nb  = 64'd1;
      while (den != 64'd0) begin
         quo = num / den;
         rem = num % den;
         num = den;
         den = rem;
         nxt = ca - quo * na;
         ca  = na;
         na  = nxt;
         nxt = cb - quo * nb;
         cb  = nb;
         nb  = nxt;
      end
      res.divisor = num[OPND_W-1:0];
      res.coef_a  = ca[COEF_W-1:0];
      res.coef_b  = cb[COEF_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      fail_count++;
   endtask

   // one operand pair over the request channel; valid stays high into the next call
   task automatic send_operands(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b);
      int unsigned gap;
      if (gap_percent != 0 && $urandom_range(0, 99) < gap_percent) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_bezout = {pending_bezout, compute_bezout(a, b)};
   endtask

   // receiver back-pressure in bursts of random length
   always @(posedge clock) begin
      if (stall_percent == 0) begin
         rsp_tready <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 99) < stall_percent) begin
         rsp_tready <= 1'b0;
         ready_hold <= $urandom_range(0, 13);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      bezout_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(bezout_type)-1:0];
         if (pending_bezout.size() == 0) begin
            report_mismatch($sformatf("unexpected result divisor=%0h", got.divisor));
         end else begin
            want = pending_bezout.pop_front();
            if (got.divisor !== want.divisor)
               report_mismatch($sformatf("divisor got %0h want %0h",
                                         got.divisor, want.divisor));
            if (got.coef_a !== want.coef_a)
               report_mismatch($sformatf("coef_a got %0h want %0h (divisor %0h)",
                                         got.coef_a, want.coef_a, want.divisor));
            if (got.coef_b !== want.coef_b)
               report_mismatch($sformatf("coef_b got %0h want %0h (divisor %0h)",
                                         got.coef_b, want.coef_b, want.divisor));
         end
      end
   end

   // hang detection: no transfer on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // zero on either side, both zero
   task automatic test_degenerate_operands();
      send_operands(32'd0, 32'd0);
      send_operands(32'd5, 32'd0);
      send_operands(32'hffff_ffff, 32'd0);
      send_operands(32'd0, 32'd7);
      send_operands(32'd0, 32'hffff_ffff);
   endtask

   // field extremes, ones, equal operands, powers of two, a below b
   task automatic test_operand_extremes();
      send_operands(32'hffff_ffff, 32'hffff_ffff);
      send_operands(32'd1, 32'd1);
      send_operands(32'd1, 32'hffff_ffff);
      send_operands(32'hffff_ffff, 32'd1);
      send_operands(32'hffff_ffff, 32'hffff_fffe);
      send_operands(32'hffff_fffe, 32'hffff_ffff);
      send_operands(32'h8000_0000, 32'h4000_0000);
      send_operands(32'h8000_0000, 32'd1);
      send_operands(32'hffff_ffff, 32'h8000_0000);
      send_operands(32'd12345, 32'd12345);
      send_operands(32'd6, 32'd35);
      send_operands(32'h5555_5555, 32'haaaa_aaaa);
   endtask

   // adjacent fibonacci numbers give the most steps and the largest coefficients
   task automatic test_longest_chains();
      send_operands(32'd2971215073, 32'd1836311903);
      send_operands(32'd1836311903, 32'd2971215073);
      send_operands(32'd1836311903, 32'd1134903170);
   endtask

   task automatic test_random_operands(input int unsigned count);
      logic [63:0]       f_lo, f_hi, f_nx;
      logic [OPND_W-1:0] a, b, g;
      int unsigned       idx;
      repeat (count) begin
         case ($urandom_range(0, 19))
            0, 1, 2: begin
               a = $urandom_range(0, 255);
               b = $urandom_range(0, 255);
            end
            3: begin
               a = $urandom();
               b = 32'd0;
            end
            4: begin
               a = 32'd0;
               b = $urandom();
            end
            5, 6: begin
               // common random factor, so the divisor is usually not one
               g = $urandom_range(1, 65535);
               a = g * $urandom_range(0, 65535);
               b = g * $urandom_range(0, 65535);
            end
            7: begin
               f_lo = 64'd0;
               f_hi = 64'd1;
               idx  = $urandom_range(2, 46);
               repeat (idx) begin
                  f_nx = f_lo + f_hi;
                  f_lo = f_hi;
                  f_hi = f_nx;
               end
               a = f_hi[OPND_W-1:0];
               b = f_lo[OPND_W-1:0];
               if ($urandom_range(0, 1) == 1) {a, b} = {b, a};
            end
            8: begin
               a = $urandom();
               b = a ^ (32'd1 << $urandom_range(0, 31));
            end
            default: begin
               a = $urandom();
               b = $urandom();
            end
         endcase
         send_operands(a, b);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      gap_percent   = 20;
      stall_percent = 20;
      test_degenerate_operands();
      test_operand_extremes();
      test_longest_chains();

      gap_percent   = 35;
      stall_percent = 30;
      test_random_operands(300);

      gap_percent   = 0;
      stall_percent = 0;
      test_random_operands(300);

      gap_percent   = 10;
      stall_percent = 8;
      test_random_operands(400);

      // closing stretch runs at full rate
      gap_percent   = 0;
      stall_percent = 0;
      test_random_operands(150);
      req_tvalid <= 1'b0;

      while (pending_bezout.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
